// ----- hw/rtl/toe_pkg.sv -----
// Shared types and constants for the text offset tab expander.
package toe_pkg;

  localparam logic [15:0] CH_BS  = 16'h0008;
  localparam logic [15:0] CH_TAB = 16'h0009;
  localparam logic [15:0] CH_LF  = 16'h000A;
  localparam logic [15:0] CH_FF  = 16'h000C;
  localparam logic [15:0] CH_CR  = 16'h000D;
  localparam logic [15:0] CH_SP  = 16'h0020;
  localparam logic [15:0] CTRL_MAX   = 16'h001F;
  localparam logic [15:0] SKIP_LO    = 16'h00C1;
  localparam logic [15:0] SKIP_HI    = 16'h00CF;
  localparam logic [5:0]  MAX_OFFSET = 6'd56;
  localparam logic [5:0]  TAB_REST   = 6'd7;

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_EXPAND_TABS = 2'd0;
  localparam logic [1:0] REG_CR_BEFORE_NL = 2'd1;
  localparam logic [1:0] REG_LINE_OFFSET = 2'd2;

  typedef struct packed {
    logic       expand_tabs;
    logic       cr_before_newline;
    logic [5:0] line_offset;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic plan_empty;
    logic cnt_zero;
  } status_t;

endpackage

// ----- hw/rtl/toe_regs.sv -----
// Configuration register file behind the APB-style port.
module toe_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [toe_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output toe_pkg::cfg_t               cfg
);
  import toe_pkg::*;

  logic wr_en;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_EXPAND_TABS:  cfg.expand_tabs <= pwdata[0];
        REG_CR_BEFORE_NL: cfg.cr_before_newline <= pwdata[0];
        REG_LINE_OFFSET:  cfg.line_offset <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EXPAND_TABS:  prdata = {31'd0, cfg.expand_tabs};
      REG_CR_BEFORE_NL: prdata = {31'd0, cfg.cr_before_newline};
      REG_LINE_OFFSET:  prdata = {26'd0, cfg.line_offset};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/toe_ctrl.sv -----
// Sequencer that accepts characters and steps out inserted runs.
module toe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  toe_pkg::status_t st,
  output toe_pkg::cmd_t    cmd,
  output logic             busy
);
  import toe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = st.out_free;
        if (st.out_free && in_valid) begin
          cmd.load = 1'b1;
          if (!st.plan_empty) state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (st.out_free) begin
          cmd.step = 1'b1;
          if (st.cnt_zero) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state == ST_RUN);

endmodule

// ----- hw/rtl/toe_dp.sv -----
// Datapath: column tracking, run planning and the output register.
module toe_dp (
  input  logic              clk,
  input  logic              rst,
  input  toe_pkg::cfg_t     cfg,
  input  logic [15:0]       char_in,
  input  toe_pkg::cmd_t     cmd,
  output toe_pkg::status_t  st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       char_out,
  output logic              last_of_run
);
  import toe_pkg::*;

  logic [15:0] column, column_next;
  logic [5:0]  cnt;
  logic [15:0] pre_char, final_char;

  logic [5:0]  plan_pre;
  logic [15:0] plan_pre_char, plan_final;
  logic [5:0]  off;
  logic        col0;

  assign off  = (cfg.line_offset > MAX_OFFSET) ? MAX_OFFSET : cfg.line_offset;
  assign col0 = (column == 16'd0);

  always_comb begin
    plan_pre      = '0;
    plan_pre_char = CH_SP;
    plan_final    = char_in;
    column_next   = column;
    if (char_in == CH_LF) begin
      plan_pre      = {5'd0, cfg.cr_before_newline};
      plan_pre_char = CH_CR;
      column_next   = 16'd0;
    end else if (char_in == CH_FF) begin
      plan_final = CH_FF;
    end else if (col0) begin
      column_next = 16'd1;
      plan_pre    = off;
      if (char_in == CH_TAB) begin
        if (cfg.expand_tabs) begin
          plan_pre    = off + TAB_REST;
          plan_final  = CH_SP;
          column_next = 16'd8;
        end else begin
          plan_pre = off + 6'd1;
        end
      end
    end else if (char_in == CH_TAB && cfg.expand_tabs) begin
      plan_pre    = {3'd0, ~column[2:0]};
      plan_final  = CH_SP;
      column_next = {column[15:3] + 13'd1, 3'd0};
    end else if (char_in == CH_BS) begin
      column_next = column - 16'd1;
    end else if (char_in > CTRL_MAX && !(char_in inside {[SKIP_LO:SKIP_HI]})) begin
      column_next = column + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        column     <= column_next;
        pre_char   <= plan_pre_char;
        final_char <= plan_final;
        out_valid  <= 1'b1;
        if (plan_pre == 6'd0) begin
          char_out    <= plan_final;
          last_of_run <= 1'b1;
        end else begin
          cnt         <= plan_pre - 6'd1;
          char_out    <= plan_pre_char;
          last_of_run <= 1'b0;
        end
      end else if (cmd.step) begin
        out_valid <= 1'b1;
        if (cnt == 6'd0) begin
          char_out    <= final_char;
          last_of_run <= 1'b1;
        end else begin
          cnt         <= cnt - 6'd1;
          char_out    <= pre_char;
          last_of_run <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.out_free   = !out_valid || out_ready;
  assign st.plan_empty = (plan_pre == 6'd0);
  assign st.cnt_zero   = (cnt == 6'd0);

endmodule

// ----- hw/rtl/text_offset_tab_expander.sv -----
// The first output beat is registered from the accepted input beat and shows in the cycle after it is taken.
// Throughput: one character per cycle when it yields a single output beat and m_tready does not stall the output.
// A character yielding N beats (offset spaces, tab fill, CR) holds the input until its last beat is loaded.
// Reset clears the column, the run counter, the configuration registers and the output valid flag.
module text_offset_tab_expander (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,  // [15:0] char_in
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,  // [15:0] char_out
  output logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [toe_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import toe_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;
  logic    busy;

  assign pready = 1'b1;

  toe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  toe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  toe_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .char_in     (s_tdata),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .char_out    (m_tdata),
    .last_of_run (m_tlast)
  );

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat did not load the output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input taken while a run is in progress");

  a_partial_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> busy)
    else $error("non-final beat shown with sequencer idle");

endmodule
